/* hdl/ccma_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and constants of the compass circular moving average.
// No dependencies; every other file imports this package.

package ccma_pkg;

	localparam int MAX_SAMPLES = 64;
	localparam int TRIG_BITS   = 16;

	localparam int PTR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int WIN_W = 7;
	localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
	localparam int SUM_W = TRIG_BITS + CNT_W;

	localparam int VEC_SHIFT = 24;
	localparam int DP_W      = SUM_W + VEC_SHIFT + 2;
	localparam int Z_W       = 25;
	localparam int ITER_W    = $clog2(TRIG_BITS);
	localparam int ATAN_IDX_W = 5;

	localparam int AZ_W  = 17;
	localparam int ANG_W = 16;

	localparam int FULL_TURN    = 36000;
	localparam int HALF_TURN    = 18000;
	localparam int QUARTER_TURN = 9000;
	localparam int ANG_UNIT_SH  = 8;
	localparam int REST_W       = $clog2(QUARTER_TURN);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = WIN_W;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SUPPRESS = CFG_IDX_W'(1);

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_DIRECT,
		KIND_SMOOTH,
		KIND_CLEAR
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [ANG_W-1:0]   angle;
	} item_t;

	typedef struct packed {
		logic [WIN_W-1:0] window;
		logic             suppress;
		logic             ring_clear;
	} cfg_t;

	typedef struct packed {
		logic                    go;
		logic                    vec;
		logic signed [DP_W-1:0]  x;
		logic signed [DP_W-1:0]  y;
		logic signed [Z_W-1:0]   z;
	} cordic_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [DP_W-1:0]  x;
		logic signed [DP_W-1:0]  y;
		logic signed [Z_W-1:0]   z;
	} cordic_rsp_t;

	// atan(2^-i) in 1/256 hundredth of a degree
	function automatic logic signed [Z_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] i);
		logic signed [Z_W-1:0] v;
		case (i)
			5'd0:    v = Z_W'(1152000);
			5'd1:    v = Z_W'(680065);
			5'd2:    v = Z_W'(359328);
			5'd3:    v = Z_W'(182400);
			5'd4:    v = Z_W'(91554);
			5'd5:    v = Z_W'(45822);
			5'd6:    v = Z_W'(22916);
			5'd7:    v = Z_W'(11459);
			5'd8:    v = Z_W'(5730);
			5'd9:    v = Z_W'(2865);
			5'd10:   v = Z_W'(1432);
			5'd11:   v = Z_W'(716);
			5'd12:   v = Z_W'(358);
			5'd13:   v = Z_W'(179);
			5'd14:   v = Z_W'(90);
			5'd15:   v = Z_W'(45);
			5'd16:   v = Z_W'(22);
			5'd17:   v = Z_W'(11);
			5'd18:   v = Z_W'(6);
			5'd19:   v = Z_W'(3);
			5'd20:   v = Z_W'(1);
			5'd21:   v = Z_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* hdl/ccma_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: azimuth requests, results, register writes.
// Depends on ccma_pkg.

interface ccma_smp_if;
	import ccma_pkg::*;
	logic                   valid;
	logic                   ready;
	logic                   cmd;
	logic signed [AZ_W-1:0] azimuth;
	modport source (output valid, cmd, azimuth, input ready);
	modport sink   (input valid, cmd, azimuth, output ready);
endinterface

interface ccma_res_if;
	import ccma_pkg::*;
	logic             valid;
	logic             ready;
	logic [ANG_W-1:0] orientation;
	logic             orientation_valid;
	logic             changed;
	logic             notify;
	modport source (output valid, orientation, orientation_valid, changed, notify, input ready);
	modport sink   (input valid, orientation, orientation_valid, changed, notify, output ready);
endinterface

interface ccma_cfg_if;
	import ccma_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/ccma_front.sv */
`timescale 1ns / 1ps
// Front end: takes requests, wraps the azimuth into 0..35999, classifies them.
// Depends on ccma_pkg and ccma_if.

module ccma_front (
	ccma_smp_if.sink        smp,
	input  ccma_pkg::cfg_t  cfg,
	input  logic            full,
	output logic            push,
	output ccma_pkg::item_t item
);
	import ccma_pkg::*;

	localparam logic [AZ_W:0] BIAS  = (AZ_W+1)'(2 * FULL_TURN);
	localparam logic [AZ_W:0] TURN1 = (AZ_W+1)'(FULL_TURN);
	localparam logic [AZ_W:0] TURN2 = (AZ_W+1)'(2 * FULL_TURN);
	localparam logic [AZ_W:0] TURN3 = (AZ_W+1)'(3 * FULL_TURN);

	logic [AZ_W:0] az_biased;
	logic [AZ_W:0] az_mod;

	// bias by two turns so the value is positive, then take off whole turns
	assign az_biased = {smp.azimuth[AZ_W-1], smp.azimuth} + BIAS;

	always_comb begin
		if (az_biased >= TURN3) begin
			az_mod = az_biased - TURN3;
		end else if (az_biased >= TURN2) begin
			az_mod = az_biased - TURN2;
		end else if (az_biased >= TURN1) begin
			az_mod = az_biased - TURN1;
		end else begin
			az_mod = az_biased;
		end
	end

	always_comb begin
		item.angle = az_mod[ANG_W-1:0];
		if (smp.cmd) begin
			item.kind = KIND_CLEAR;
		end else if (cfg.window == '0) begin
			item.kind = KIND_DIRECT;
		end else begin
			item.kind = KIND_SMOOTH;
		end
	end

	assign smp.ready = !full;
	assign push      = smp.valid && !full;

endmodule

/* hdl/ccma_queue.sv */
`timescale 1ns / 1ps
// Short queue between front end and back end.
// Depends on ccma_pkg.

module ccma_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ccma_pkg::item_t wr_item,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output ccma_pkg::item_t rd_item
);
	import ccma_pkg::*;

	localparam int Q_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [Q_PTR_W-1:0] LAST = Q_PTR_W'(QUEUE_DEPTH - 1);

	item_t               slot_q [QUEUE_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = count_q == Q_CNT_W'(QUEUE_DEPTH);
	assign valid   = count_q != '0;
	assign rd_item = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + Q_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

/* hdl/ccma_cordic.sv */
`timescale 1ns / 1ps
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on ccma_pkg.

module ccma_cordic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ccma_pkg::cordic_req_t req,
	output ccma_pkg::cordic_rsp_t rsp
);
	import ccma_pkg::*;

	localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(TRIG_BITS - 1);

	logic                   busy_q;
	logic                   done_q;
	logic                   vec_q;
	logic [ITER_W-1:0]      iter_q;
	logic signed [DP_W-1:0] x_q;
	logic signed [DP_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;
	logic signed [DP_W-1:0] dx;
	logic signed [DP_W-1:0] dy;
	logic signed [Z_W-1:0]  dz;
	logic                   neg;

	assign dx = y_q >>> iter_q;
	assign dy = x_q >>> iter_q;
	assign dz = atan_entry(ATAN_IDX_W'(iter_q));
	// rotation steers on the residual angle, vectoring on the sign of y
	assign neg = vec_q ? !y_q[DP_W-1] : z_q[Z_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				if (iter_q == LAST_ITER) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					iter_q <= iter_q + ITER_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			vec_q <= req.vec;
			x_q   <= req.x;
			y_q   <= req.y;
			z_q   <= req.z;
		end else if (busy_q) begin
			if (!neg) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - dz;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + dz;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.x    = x_q;
	assign rsp.y    = y_q;
	assign rsp.z    = z_q;

endmodule

/* hdl/ccma_back.sv */
`timescale 1ns / 1ps
// Back end: sine/cosine ring, running sums, atan2 sequencing and result register.
// Depends on ccma_pkg, ccma_if; drives the shared ccma_cordic.

module ccma_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ccma_pkg::cfg_t        cfg,
	input  logic                  q_valid,
	input  ccma_pkg::item_t       q_item,
	output logic                  q_pop,
	output ccma_pkg::cordic_req_t creq,
	input  ccma_pkg::cordic_rsp_t crsp,
	ccma_res_if.source            res
);
	import ccma_pkg::*;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_ROT       = 3'd1;
	localparam logic [2:0] ST_ACC       = 3'd2;
	localparam logic [2:0] ST_VEC_START = 3'd3;
	localparam logic [2:0] ST_VEC       = 3'd4;
	localparam logic [2:0] ST_WRAP      = 3'd5;
	localparam logic [2:0] ST_DONE      = 3'd6;

	localparam int RND_W   = Z_W - ANG_UNIT_SH;
	localparam int TRIG_SH = 31 - TRIG_BITS;
	localparam logic signed [DP_W-1:0]      TRIG_RND  = DP_W'(1 << (TRIG_SH - 1));
	localparam logic signed [DP_W-1:0]      TRIG_LIM  = DP_W'((1 << (TRIG_BITS - 1)) - 1);
	localparam logic signed [DP_W-1:0]      CORDIC_GAIN = DP_W'(652032875);
	localparam logic signed [Z_W-1:0]       Z_HALF    = Z_W'(HALF_TURN << ANG_UNIT_SH);
	localparam logic signed [Z_W-1:0]       Z_RND     = Z_W'(1 << (ANG_UNIT_SH - 1));
	localparam logic signed [RND_W-1:0]     R_TURN    = RND_W'(FULL_TURN);
	localparam logic [ANG_W-1:0]            Q1 = ANG_W'(QUARTER_TURN);
	localparam logic [ANG_W-1:0]            Q2 = ANG_W'(2 * QUARTER_TURN);
	localparam logic [ANG_W-1:0]            Q3 = ANG_W'(3 * QUARTER_TURN);

	// round half up to the output fraction and saturate symmetrically
	function automatic logic signed [TRIG_BITS-1:0] to_trig(input logic signed [DP_W-1:0] v);
		logic signed [DP_W-1:0] t;
		t = (v + TRIG_RND) >>> TRIG_SH;
		if (t > TRIG_LIM) begin
			t = TRIG_LIM;
		end else if (t < -TRIG_LIM) begin
			t = -TRIG_LIM;
		end
		return t[TRIG_BITS-1:0];
	endfunction

	logic [2:0]                  state_q;
	kind_t                       kind_q;
	logic [1:0]                  quad_q;
	logic [PTR_W-1:0]            p_q;
	logic [ANG_W-1:0]            orient_q;
	logic signed [RND_W-1:0]     r_q;
	logic signed [TRIG_BITS-1:0] s_q;
	logic signed [TRIG_BITS-1:0] c_q;
	logic signed [TRIG_BITS-1:0] rd_s_q;
	logic signed [TRIG_BITS-1:0] rd_c_q;
	logic signed [TRIG_BITS-1:0] sin_mem [MAX_SAMPLES];
	logic signed [TRIG_BITS-1:0] cos_mem [MAX_SAMPLES];

	logic [PTR_W-1:0]            wp_q;
	logic [CNT_W-1:0]            fill_q;
	logic signed [SUM_W-1:0]     sum_s_q;
	logic signed [SUM_W-1:0]     sum_c_q;
	logic [ANG_W-1:0]            last_orient_q;
	logic                        last_known_q;

	logic                        res_valid_q;
	logic [ANG_W-1:0]            res_orient_q;
	logic                        res_ovalid_q;
	logic                        res_changed_q;
	logic                        res_notify_q;

	logic [CMP_W-1:0]            w;
	logic [PTR_W-1:0]            p_sel;
	logic                        ring_full;
	logic                        wp_wrap;
	logic [1:0]                  quad;
	logic [REST_W-1:0]           rest;
	logic                        start_rot;
	logic                        start_vec;
	logic                        sums_zero;
	logic                        vec_flip;
	logic signed [DP_W-1:0]      vx;
	logic signed [DP_W-1:0]      vy;
	logic signed [TRIG_BITS-1:0] sr;
	logic signed [TRIG_BITS-1:0] cr;
	logic signed [TRIG_BITS-1:0] s_map;
	logic signed [TRIG_BITS-1:0] c_map;
	logic signed [SUM_W-1:0]     sub_s;
	logic signed [SUM_W-1:0]     sub_c;
	logic signed [Z_W-1:0]       z_rnd;
	logic                        load_res;
	logic                        is_clear;
	logic                        chg;

	assign w = (CMP_W'(cfg.window) > CMP_W'(MAX_SAMPLES)) ? CMP_W'(MAX_SAMPLES)
		: CMP_W'(cfg.window);
	assign p_sel     = (CMP_W'(wp_q) < w) ? wp_q : '0;
	assign ring_full = CMP_W'(fill_q) >= w;
	assign wp_wrap   = (CMP_W'(p_q) + CMP_W'(1)) >= w;

	always_comb begin
		if (q_item.angle >= Q3) begin
			quad = 2'd3;
			rest = REST_W'(q_item.angle - Q3);
		end else if (q_item.angle >= Q2) begin
			quad = 2'd2;
			rest = REST_W'(q_item.angle - Q2);
		end else if (q_item.angle >= Q1) begin
			quad = 2'd1;
			rest = REST_W'(q_item.angle - Q1);
		end else begin
			quad = 2'd0;
			rest = REST_W'(q_item.angle);
		end
	end

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign start_rot = q_pop && (q_item.kind == KIND_SMOOTH);
	assign sums_zero = (sum_s_q == '0) && (sum_c_q == '0);
	assign start_vec = (state_q == ST_VEC_START) && !sums_zero;

	// sums scaled up; a vector in the left half plane is turned half a circle first
	assign vec_flip = sum_c_q[SUM_W-1];
	assign vx = DP_W'(sum_c_q) <<< VEC_SHIFT;
	assign vy = DP_W'(sum_s_q) <<< VEC_SHIFT;

	always_comb begin
		creq.go  = start_rot || start_vec;
		creq.vec = start_vec;
		if (start_vec) begin
			creq.x = vec_flip ? -vx : vx;
			creq.y = vec_flip ? -vy : vy;
			creq.z = vec_flip ? Z_HALF : '0;
		end else begin
			creq.x = CORDIC_GAIN;
			creq.y = '0;
			creq.z = Z_W'({rest, {ANG_UNIT_SH{1'b0}}});
		end
	end

	assign sr = to_trig(crsp.y);
	assign cr = to_trig(crsp.x);

	always_comb begin
		case (quad_q)
			2'd0: begin
				s_map = sr;
				c_map = cr;
			end
			2'd1: begin
				s_map = cr;
				c_map = -sr;
			end
			2'd2: begin
				s_map = -sr;
				c_map = -cr;
			end
			default: begin
				s_map = -cr;
				c_map = sr;
			end
		endcase
	end

	assign sub_s = ring_full ? SUM_W'(rd_s_q) : '0;
	assign sub_c = ring_full ? SUM_W'(rd_c_q) : '0;
	assign z_rnd = (crsp.z + Z_RND) >>> ANG_UNIT_SH;

	assign load_res = (state_q == ST_DONE) && (!res_valid_q || res.ready);
	assign is_clear = kind_q == KIND_CLEAR;
	assign chg      = !is_clear && (!last_known_q || last_orient_q != orient_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			wp_q          <= '0;
			fill_q        <= '0;
			sum_s_q       <= '0;
			sum_c_q       <= '0;
			last_orient_q <= '0;
			last_known_q  <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= (q_item.kind == KIND_SMOOTH) ? ST_ROT : ST_DONE;
					end
				end
				ST_ROT: begin
					if (crsp.done) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					sum_s_q <= sum_s_q + SUM_W'(s_q) - sub_s;
					sum_c_q <= sum_c_q + SUM_W'(c_q) - sub_c;
					if (!ring_full) begin
						fill_q <= fill_q + CNT_W'(1);
					end
					wp_q    <= wp_wrap ? '0 : p_q + PTR_W'(1);
					state_q <= ST_VEC_START;
				end
				ST_VEC_START: begin
					state_q <= sums_zero ? ST_DONE : ST_VEC;
				end
				ST_VEC: begin
					if (crsp.done) begin
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_res) begin
						last_known_q <= !is_clear;
						if (is_clear) begin
							wp_q    <= '0;
							fill_q  <= '0;
							sum_s_q <= '0;
							sum_c_q <= '0;
						end else begin
							last_orient_q <= orient_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg.ring_clear) begin
				wp_q    <= '0;
				fill_q  <= '0;
				sum_s_q <= '0;
				sum_c_q <= '0;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					kind_q   <= q_item.kind;
					quad_q   <= quad;
					p_q      <= p_sel;
					orient_q <= (q_item.kind == KIND_DIRECT) ? q_item.angle : '0;
				end
			end
			ST_ROT: begin
				if (crsp.done) begin
					s_q <= s_map;
					c_q <= c_map;
				end
			end
			ST_VEC_START: begin
				orient_q <= '0;
			end
			ST_VEC: begin
				if (crsp.done) begin
					r_q <= z_rnd[RND_W-1:0];
				end
			end
			ST_WRAP: begin
				if (r_q < 0) begin
					orient_q <= ANG_W'(r_q + R_TURN);
				end else if (r_q >= R_TURN) begin
					orient_q <= ANG_W'(r_q - R_TURN);
				end else begin
					orient_q <= ANG_W'(r_q);
				end
			end
			default: begin
			end
		endcase
		if (load_res) begin
			res_orient_q  <= orient_q;
			res_ovalid_q  <= !is_clear;
			res_changed_q <= chg;
			res_notify_q  <= is_clear || (chg && !cfg.suppress);
		end
	end

	// ring memories: oldest entry read when the sample is taken, new one written later
	always_ff @(posedge clk) begin
		if (state_q == ST_ACC) begin
			sin_mem[p_q] <= s_q;
			cos_mem[p_q] <= c_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start_rot) begin
			rd_s_q <= sin_mem[p_sel];
			rd_c_q <= cos_mem[p_sel];
		end
	end

	assign res.valid             = res_valid_q;
	assign res.orientation       = res_orient_q;
	assign res.orientation_valid = res_ovalid_q;
	assign res.changed           = res_changed_q;
	assign res.notify            = res_notify_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_SAMPLES))
		else $error("ring fill count above capacity");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ovalid_q |-> res_notify_q && !res_changed_q
		&& res_orient_q == '0)
		else $error("clear result malformed");

	a_orient_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_orient_q < ANG_W'(FULL_TURN))
		else $error("orientation out of range");

	a_cordic_done: assert property (@(posedge clk) disable iff (!arst_n)
		crsp.done |-> state_q == ST_ROT || state_q == ST_VEC)
		else $error("CORDIC finished outside a waiting state");

	a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q != ST_IDLE)
		else $error("request popped but sequencer stayed idle");

endmodule

/* hdl/compass_circular_moving_average.sv */
`timescale 1ns / 1ps
// Compass circular moving average. Takes azimuth requests (hundredths of a degree,
// wrapped into 0..35999) or clear commands on smp and returns one result per request
// on res. The front end wraps and classifies each request into a two-entry queue, so it
// keeps accepting while the back end works, until the queue is full. A smoothed sample
// makes a sine/cosine pass and, unless both sums are zero, an atan2 pass, 16 iterations
// each, through one shared iterative CORDIC; a clear or an unsmoothed sample (window 0)
// makes neither. Writes on cfg are taken every cycle; writing window_samples empties the
// history. Depends on ccma_pkg, ccma_if, ccma_front, ccma_queue, ccma_cordic, ccma_back.

module compass_circular_moving_average (
	input  logic       clk,
	input  logic       arst_n,
	ccma_smp_if.sink   smp,
	ccma_res_if.source res,
	ccma_cfg_if.sink   cfg
);
	import ccma_pkg::*;

	logic [WIN_W-1:0] window_q;
	logic             suppress_q;
	cfg_t             cfg_bus;
	logic             push;
	logic             full;
	item_t            wr_item;
	logic             q_valid;
	logic             q_pop;
	item_t            q_item;
	cordic_req_t      creq;
	cordic_rsp_t      crsp;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '0;
			suppress_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_WINDOW:   window_q   <= cfg.data[WIN_W-1:0];
				REG_SUPPRESS: suppress_q <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg_bus.window     = window_q;
	assign cfg_bus.suppress   = suppress_q;
	assign cfg_bus.ring_clear = cfg.valid && (cfg.index == REG_WINDOW);

	ccma_front u_front (
		.smp  (smp),
		.cfg  (cfg_bus),
		.full (full),
		.push (push),
		.item (wr_item)
	);

	ccma_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.full    (full),
		.pop     (q_pop),
		.valid   (q_valid),
		.rd_item (q_item)
	);

	ccma_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	ccma_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.creq    (creq),
		.crsp    (crsp),
		.res     (res)
	);

endmodule
